@@ rtl/core/apc_pkg.sv @@
// Shared types, constants and helper functions for the collider pair table.
package apc_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int TYPE_COUNT = 8;
  localparam int SLOT_IW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SLOT_FW    = 3;
  localparam int KIND_W     = 3;
  localparam int MASK_W     = 64;

  localparam logic [MASK_W-1:0] PAIR_MASK_RST = 64'd9116009822962252800;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_MOVE  = 2'd1;
  localparam logic [1:0] CMD_ERASE = 2'd2;
  localparam logic [1:0] CMD_SWEEP = 2'd3;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [11:0]        w;
    logic [11:0]        h;
  } apc_rect_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              listener;
  } apc_attr_t;

  // write request into the slot store
  typedef struct packed {
    logic               rect_en;
    logic               attr_en;
    logic [SLOT_IW-1:0] addr;
    apc_rect_t          rect;
    apc_attr_t          attr;
  } apc_wr_t;

  // one result item on the out_ side
  typedef struct packed {
    logic               v;
    logic               status;
    logic [SLOT_FW-1:0] slot;
    logic [SLOT_FW-1:0] other;
    logic               is_event;
    logic               last;
  } apc_res_t;

  // strict overlap; sums formed one bit wider so they never wrap
  function automatic logic rect_overlap(apc_rect_t a, apc_rect_t b);
    logic signed [16:0] ax, ay, bx, by, axe, aye, bxe, bye;
    ax  = $signed({a.x[15], a.x});
    ay  = $signed({a.y[15], a.y});
    bx  = $signed({b.x[15], b.x});
    by  = $signed({b.y[15], b.y});
    axe = ax + $signed({5'b0, a.w});
    aye = ay + $signed({5'b0, a.h});
    bxe = bx + $signed({5'b0, b.w});
    bye = by + $signed({5'b0, b.h});
    return (ax < bxe) && (axe > bx) && (ay < bye) && (aye > by);
  endfunction

  function automatic logic notified(apc_attr_t rcv, apc_attr_t oth,
                                    logic [MASK_W-1:0] mask);
    logic ok;
    ok = rcv.listener && (int'(rcv.kind) < TYPE_COUNT) && (int'(oth.kind) < TYPE_COUNT);
    return ok && mask[{rcv.kind, oth.kind}];
  endfunction

endpackage

@@ rtl/core/apc_store.sv @@
// Slot store: rectangle and attribute memories, one write and one registered read port.
module apc_store
  import apc_pkg::*;
(
  input  logic               clk,
  input  apc_wr_t            wr,
  input  logic               rd_en,
  input  logic [SLOT_IW-1:0] rd_addr,
  output apc_rect_t          rd_rect,
  output apc_attr_t          rd_attr
);

  apc_rect_t rect_mem [SLOT_COUNT];
  apc_attr_t attr_mem [SLOT_COUNT];
  apc_rect_t rd_rect_r;
  apc_attr_t rd_attr_r;

  always_ff @(posedge clk) begin
    if (wr.rect_en) begin
      rect_mem[wr.addr] <= wr.rect;
    end
    if (wr.attr_en) begin
      attr_mem[wr.addr] <= wr.attr;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_rect_r <= rect_mem[rd_addr];
      rd_attr_r <= attr_mem[rd_addr];
    end
  end

  assign rd_rect = rd_rect_r;
  assign rd_attr = rd_attr_r;

endmodule

@@ rtl/core/apc_sweep.sv @@
// Pair sweep sequencer: walks slot pairs through the store read port and emits events.
module apc_sweep
  import apc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic [SLOT_COUNT-1:0] used,
  input  logic [MASK_W-1:0]     pair_mask,
  output logic                  busy,
  output logic                  rd_en,
  output logic [SLOT_IW-1:0]    rd_addr,
  input  apc_rect_t             rd_rect,
  input  apc_attr_t             rd_attr,
  output apc_res_t              res
);

  localparam logic [SLOT_IW-1:0] LAST_SLOT = SLOT_IW'(SLOT_COUNT - 1);
  localparam logic [SLOT_IW-1:0] PEN_SLOT  = SLOT_IW'(SLOT_COUNT - 2);

  logic               sweep_on_r, issuing_r;
  logic [SLOT_IW-1:0] ii_r, kk_r;
  logic               tag_v_r, tag_ld_r;
  logic [SLOT_IW-1:0] tag_k_r;
  logic               second_r;
  apc_rect_t          a_rect_r;
  apc_attr_t          a_attr_r;
  logic [SLOT_IW-1:0] a_idx_r;
  logic               pend_v_r;
  logic [SLOT_IW-1:0] pend_slot_r, pend_other_r;
  apc_res_t           out_r;

  logic               at_load, iss_valid, row_end, stall;
  logic               ovl, cmp_hit, e1, e2, have_ev, finish;
  logic [SLOT_IW-1:0] ev_slot, ev_other;

  // issue side
  always_comb begin
    at_load   = (kk_r == ii_r);
    rd_addr   = at_load ? ii_r : kk_r;
    iss_valid = at_load ? used[ii_r] : (used[ii_r] && used[kk_r]);
    row_end   = at_load ? !used[ii_r] : (kk_r == LAST_SLOT);
  end

  // compare side: tag_k_r is the slot whose data sits on the read port
  always_comb begin
    ovl      = rect_overlap(a_rect_r, rd_rect);
    cmp_hit  = tag_v_r && !tag_ld_r && ovl;
    e1       = cmp_hit && notified(a_attr_r, rd_attr, pair_mask);
    e2       = cmp_hit && notified(rd_attr, a_attr_r, pair_mask);
    stall    = e1 && e2 && !second_r;
    have_ev  = second_r || e1 || e2;
    ev_slot  = (second_r || !e1) ? tag_k_r : a_idx_r;
    ev_other = (second_r || !e1) ? a_idx_r : tag_k_r;
    finish   = sweep_on_r && !issuing_r && !tag_v_r;
  end

  assign rd_en = issuing_r && !stall;
  assign busy  = sweep_on_r;
  assign res   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_on_r <= 1'b0;
      issuing_r  <= 1'b0;
      tag_v_r    <= 1'b0;
      second_r   <= 1'b0;
      pend_v_r   <= 1'b0;
      out_r      <= '0;
      ii_r       <= '0;
      kk_r       <= '0;
    end else if (go) begin
      sweep_on_r <= 1'b1;
      issuing_r  <= 1'b1;
      tag_v_r    <= 1'b0;
      second_r   <= 1'b0;
      pend_v_r   <= 1'b0;
      out_r      <= '0;
      ii_r       <= '0;
      kk_r       <= '0;
    end else begin
      out_r    <= '0;
      second_r <= stall;
      if (!stall) begin
        tag_v_r  <= issuing_r && iss_valid;
        tag_ld_r <= at_load;
        tag_k_r  <= rd_addr;
        if (issuing_r) begin
          if (row_end) begin
            if (ii_r == PEN_SLOT) begin
              issuing_r <= 1'b0;
            end else begin
              ii_r <= ii_r + 1'b1;
              kk_r <= ii_r + 1'b1;
            end
          end else begin
            kk_r <= kk_r + 1'b1;
          end
        end
      end
      if (tag_v_r && tag_ld_r) begin
        a_rect_r <= rd_rect;
        a_attr_r <= rd_attr;
        a_idx_r  <= tag_k_r;
      end
      // one event held back so the final one can carry last
      if (finish) begin
        sweep_on_r     <= 1'b0;
        out_r.v        <= 1'b1;
        out_r.status   <= ST_OK;
        out_r.is_event <= pend_v_r;
        out_r.last     <= 1'b1;
        out_r.slot     <= pend_v_r ? SLOT_FW'(pend_slot_r) : '0;
        out_r.other    <= pend_v_r ? SLOT_FW'(pend_other_r) : '0;
        pend_v_r       <= 1'b0;
      end else if (have_ev) begin
        if (pend_v_r) begin
          out_r.v        <= 1'b1;
          out_r.status   <= ST_OK;
          out_r.is_event <= 1'b1;
          out_r.last     <= 1'b0;
          out_r.slot     <= SLOT_FW'(pend_slot_r);
          out_r.other    <= SLOT_FW'(pend_other_r);
        end
        pend_v_r     <= 1'b1;
        pend_slot_r  <= ev_slot;
        pend_other_r <= ev_other;
      end
    end
  end

  a_stall_single: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> !stall)
    else $error("sweep stalled two cycles on one pair");

  a_issue_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (issuing_r || tag_v_r || pend_v_r) |-> sweep_on_r)
    else $error("sweep pipeline active outside a sweep");

  a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && !go) |=> (out_r.v && out_r.last && !sweep_on_r))
    else $error("sweep ended without a last result");

endmodule

@@ rtl/core/aabb_pair_collision_table.sv @@
// Top level of the collider pair table: command decode, slot occupancy and result port.
//
// Commands transfer on in_* when start is high and busy is low.
// Add, move and erase finish at the transfer edge; their single result
// (last=1) shows on out_* with out_strobe in the following cycle, and busy
// stays low, so a new command may follow in every cycle.
// Sweep raises busy from the next cycle. The sequencer reads one slot per
// cycle from the slot memory while it does not stall: one read per row slot
// (every slot but the last) and one per later slot of a used row, and it
// stalls for each overlapping pair that notifies both sides; compare and
// wind-down follow the last read. Each event is held back until the next
// one or the end of the sweep, so the last one can carry out_last; a sweep
// without events gives one empty result with out_last. busy falls in the
// cycle that shows that last result.
// out_strobe marks each result for exactly one cycle; the receiver cannot
// stall and must take every transfer.
// cfg_wr_en writes cfg_wr_data into the pair mask; write only while idle.
// Reset (rst_n low, synchronous) empties every slot and restores the mask.
module aabb_pair_collision_table
  import apc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_command,
  input  logic [2:0]        in_slot,
  input  logic signed [15:0] in_rect_x,
  input  logic signed [15:0] in_rect_y,
  input  logic [11:0]       in_rect_w,
  input  logic [11:0]       in_rect_h,
  input  logic [2:0]        in_kind,
  input  logic              in_has_listener,
  output logic              out_strobe,
  output logic              out_status,
  output logic [2:0]        out_slot_out,
  output logic [2:0]        out_other_slot,
  output logic              out_is_event,
  output logic              out_last,
  input  logic              cfg_wr_en,
  input  logic [63:0]       cfg_wr_data
);

  logic [MASK_W-1:0]     pair_mask_r;
  logic [SLOT_COUNT-1:0] used_r;
  logic                  res_v_r, res_status_r;
  logic [SLOT_FW-1:0]    res_slot_r;

  logic                  accept, sweep_go, slot_ok, slot_used;
  logic                  free_found;
  logic [SLOT_IW-1:0]    free_idx, tgt_idx;
  apc_wr_t               wr;
  logic                  rd_en;
  logic [SLOT_IW-1:0]    rd_addr;
  apc_rect_t             rd_rect;
  apc_attr_t             rd_attr;
  apc_res_t              sw_res;

  always_comb begin
    accept    = start && !busy;
    sweep_go  = accept && (in_command == CMD_SWEEP);
    slot_ok   = (int'(in_slot) < SLOT_COUNT);
    tgt_idx   = in_slot[SLOT_IW-1:0];
    slot_used = slot_ok && used_r[tgt_idx];
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used_r[SLOT_IW'(i)]) begin
        free_found = 1'b1;
        free_idx   = SLOT_IW'(i);
      end
    end
    wr.rect.x        = in_rect_x;
    wr.rect.y        = in_rect_y;
    wr.rect.w        = in_rect_w;
    wr.rect.h        = in_rect_h;
    wr.attr.kind     = in_kind;
    wr.attr.listener = in_has_listener;
    wr.addr    = (in_command == CMD_ADD) ? free_idx : tgt_idx;
    wr.attr_en = accept && (in_command == CMD_ADD) && free_found;
    wr.rect_en = wr.attr_en || (accept && (in_command == CMD_MOVE) && slot_used);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_mask_r <= PAIR_MASK_RST;
      used_r      <= '0;
      res_v_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pair_mask_r <= cfg_wr_data;
      end
      res_v_r <= accept && (in_command != CMD_SWEEP);
      if (accept) begin
        case (in_command)
          CMD_ADD: begin
            if (free_found) begin
              used_r[free_idx] <= 1'b1;
            end
            res_status_r <= free_found ? ST_OK : ST_FAIL;
            res_slot_r   <= free_found ? SLOT_FW'(free_idx) : '0;
          end
          CMD_MOVE: begin
            res_status_r <= slot_used ? ST_OK : ST_FAIL;
            res_slot_r   <= in_slot;
          end
          CMD_ERASE: begin
            if (slot_used) begin
              used_r[tgt_idx] <= 1'b0;
            end
            res_status_r <= slot_used ? ST_OK : ST_FAIL;
            res_slot_r   <= in_slot;
          end
          default: begin
          end
        endcase
      end
    end
  end

  apc_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_rect (rd_rect),
    .rd_attr (rd_attr)
  );

  apc_sweep u_sweep (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (sweep_go),
    .used      (used_r),
    .pair_mask (pair_mask_r),
    .busy      (busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_rect   (rd_rect),
    .rd_attr   (rd_attr),
    .res       (sw_res)
  );

  assign out_strobe     = res_v_r || sw_res.v;
  assign out_status     = sw_res.v ? sw_res.status   : res_status_r;
  assign out_slot_out   = sw_res.v ? sw_res.slot     : res_slot_r;
  assign out_other_slot = sw_res.v ? sw_res.other    : '0;
  assign out_is_event   = sw_res.v ? sw_res.is_event : 1'b0;
  assign out_last       = sw_res.v ? sw_res.last     : 1'b1;

  a_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_v_r && sw_res.v))
    else $error("command result and sweep result in one cycle");

  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> (out_strobe && out_last))
    else $error("busy fell without the last sweep result");

  a_add_full: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_command == CMD_ADD) && (&used_r)) |=> (out_strobe && out_status))
    else $error("add on a full table did not report failure");

endmodule
